// ===== rtl/hrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, codes and constants shared by the HTTP response parser modules.
// ----------------------------------------------------------------------------
package hrp_pkg;

	localparam int MAX_LINE_DEF    = 256;
	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [1:0] OP_DATA    = 2'd0;
	localparam logic [1:0] OP_EOS     = 2'd1;
	localparam logic [1:0] OP_ERROR   = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_RECV   = 3'd1;
	localparam logic [2:0] ST_HEADER = 3'd2;
	localparam logic [2:0] ST_STATUS = 3'd3;
	localparam logic [2:0] ST_NOLEN  = 3'd4;
	localparam logic [2:0] ST_TRUNC  = 3'd5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5a;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [3:0] STATUS_PFX_LEN = 4'd7;
	localparam logic [3:0] LENGTH_PFX_LEN = 4'd15;
	localparam logic [8*8-1:0]  STATUS_PFX = "http/1. ";
	localparam logic [16*8-1:0] LENGTH_PFX = "content-length: ";

	localparam logic [9:0] CODE_MAX   = 10'd999;
	localparam logic [9:0] CODE_OK_LO = 10'd200;
	localparam logic [9:0] CODE_OK_HI = 10'd300;

	typedef enum logic [1:0] {
		NUM_SKIP,
		NUM_SIGN,
		NUM_DIGITS,
		NUM_END
	} num_mode_t;

	typedef struct packed {
		num_mode_t mode;
		logic      neg;
		logic      sat;
	} num_flags_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_octet;
		logic        done_res;
		logic [2:0]  status;
		logic [9:0]  response_code;
		logic [31:0] body_length;
		logic [31:0] body_count;
	} out_t;

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_OFS : c;
	endfunction

	function automatic logic [7:0] pfx_char(logic is_status, logic [3:0] pos);
		logic [2:0] si;
		logic [3:0] li;
		si = 3'd7 - pos[2:0];
		li = 4'd15 - pos;
		return is_status ? STATUS_PFX[8*si +: 8] : LENGTH_PFX[8*li +: 8];
	endfunction

endpackage

// ===== rtl/hrp_num_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_num_step
// One character step of the decimal field reader: blanks, sign, digits,
// saturating at a cap.
// ----------------------------------------------------------------------------
module hrp_num_step #(
	parameter int ACC_W = hrp_pkg::LENGTH_BITS_DEF
) (
	input  hrp_pkg::num_flags_t num,
	input  logic [ACC_W-1:0]    acc,
	input  logic [ACC_W-1:0]    cap,
	input  logic [7:0]          ch,
	output hrp_pkg::num_flags_t num_next,
	output logic [ACC_W-1:0]    acc_next
);

	logic             blank;
	logic             digit;
	logic [3:0]       dval;
	logic [ACC_W+3:0] prod;

	assign blank = (ch == hrp_pkg::CH_SPACE) ||
		(ch >= hrp_pkg::CH_TAB && ch <= hrp_pkg::CH_CR);
	assign digit = (ch >= hrp_pkg::CH_0) && (ch <= hrp_pkg::CH_9);
	assign dval  = 4'(ch - hrp_pkg::CH_0);
	assign prod  = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (ACC_W+4)'(dval);

	always_comb begin
		num_next = num;
		acc_next = acc;
		if (num.mode == hrp_pkg::NUM_SKIP && blank) begin
			num_next = num;
		end else if (num.mode == hrp_pkg::NUM_SKIP &&
				(ch == hrp_pkg::CH_PLUS || ch == hrp_pkg::CH_MINUS)) begin
			num_next.neg  = (ch == hrp_pkg::CH_MINUS);
			num_next.mode = hrp_pkg::NUM_SIGN;
		end else if (num.mode != hrp_pkg::NUM_END && digit) begin
			if (num.mode != hrp_pkg::NUM_DIGITS) begin
				acc_next      = ACC_W'(dval);
				num_next.mode = hrp_pkg::NUM_DIGITS;
			end else if (prod > {4'd0, cap}) begin
				acc_next     = cap;
				num_next.sat = 1'b1;
			end else begin
				acc_next = prod[ACC_W-1:0];
			end
		end else begin
			num_next.mode = hrp_pkg::NUM_END;
		end
	end

endmodule

// ===== rtl/http_response_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_parser
// HTTP/1.x response parser: status line and header checks, Content-Length
// capture, body pass-through with byte count and final status.
// ----------------------------------------------------------------------------
// Takes one received byte or stream event per cycle. Each transfer lands in
// an input register and is parsed in a single pass of logic into the result
// register. The per-byte parse step sets the rate of one item per clock;
// rx_ready drops only while the result register holds a result that has not
// been taken and the waiting item would produce another one.
module http_response_parser #(
	parameter int MAX_LINE    = hrp_pkg::MAX_LINE_DEF,
	parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rx_valid,
	output logic          rx_ready,
	input  hrp_pkg::in_t  rx_item,
	output logic          res_valid,
	input  logic          res_ready,
	output hrp_pkg::out_t res_item
);

	localparam int LC_W = $clog2(MAX_LINE);
	localparam logic [LC_W-1:0] LC_LIMIT = LC_W'(MAX_LINE - 1);

	typedef enum logic [1:0] {
		PH_STATUS,
		PH_HEAD,
		PH_BODY,
		PH_DONE
	} phase_t;

	// input stage
	logic         valid_s1;
	hrp_pkg::in_t item_s1;
	logic [7:0]   ch;
	logic         adv;

	// parser state
	phase_t                 phase_q, phase_d;
	logic [LC_W-1:0]        lc_q, lc_d;
	logic [3:0]             pos_q, pos_d;
	logic                   alive_q, alive_d;
	logic                   space_q, space_d;
	logic                   cr_q, cr_d;
	logic                   tend_q, tend_d;
	hrp_pkg::num_flags_t    num_q, num_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic [9:0]             code_q, code_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic                   lseen_q, lseen_d;
	logic [LENGTH_BITS-1:0] rcv_q, rcv_d;

	// result register
	logic          res_valid_q;
	hrp_pkg::out_t res_q, res_d, res_full;
	logic          produce;

	// absorbed byte
	logic                   is_status;
	logic [3:0]             plen;
	logic [LENGTH_BITS-1:0] cap;
	hrp_pkg::num_flags_t    feed_num;
	logic [LENGTH_BITS-1:0] feed_acc;
	logic [LC_W-1:0]        ab_lc;
	logic [3:0]             ab_pos;
	logic                   ab_alive, ab_space, ab_tend;
	hrp_pkg::num_flags_t    ab_num;
	logic [LENGTH_BITS-1:0] ab_acc;

	// line end
	logic                   le_sel;
	logic [LC_W-1:0]        le_lc;
	logic                   le_cr, le_alive, le_space;
	logic [3:0]             le_pos;
	hrp_pkg::num_flags_t    le_num;
	logic [LENGTH_BITS-1:0] le_acc;
	logic                   eff_zero, hdr_ok, code_ok, len_hit;
	logic [9:0]             code_new;
	logic [LENGTH_BITS-1:0] len_new;
	logic                   el_fin, el_clear, el_code_we, el_len_we;
	logic                   el_to_head, el_to_body;
	logic [2:0]             el_st;
	logic                   run_el, eos;
	logic [LENGTH_BITS-1:0] rcv_inc;
	logic [31:0]            len_out, rcv_out;

	assign ch       = item_s1.data_byte;
	assign adv      = valid_s1 && (!produce || !res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || adv;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			item_s1 <= rx_item;
		end
	end

	// absorb one line byte
	assign is_status = (phase_q == PH_STATUS);
	assign plen      = is_status ? hrp_pkg::STATUS_PFX_LEN : hrp_pkg::LENGTH_PFX_LEN;
	assign cap       = is_status ? LENGTH_BITS'(hrp_pkg::CODE_MAX) : '1;

	hrp_num_step #(
		.ACC_W(LENGTH_BITS)
	) u_num (
		.num      (num_q),
		.acc      (acc_q),
		.cap      (cap),
		.ch       (ch),
		.num_next (feed_num),
		.acc_next (feed_acc)
	);

	always_comb begin
		ab_lc    = lc_q + 1'b1;
		ab_pos   = pos_q;
		ab_alive = alive_q;
		ab_space = space_q;
		ab_tend  = tend_q;
		ab_num   = num_q;
		ab_acc   = acc_q;
		if (!tend_q) begin
			if (ch == hrp_pkg::CH_NUL) begin
				ab_tend = 1'b1;
				if (pos_q < plen) begin
					ab_alive = 1'b0;
				end
			end else if (alive_q) begin
				if (pos_q < plen) begin
					if (hrp_pkg::to_lower(ch) != hrp_pkg::pfx_char(is_status, pos_q)) begin
						ab_alive = 1'b0;
					end else begin
						ab_pos = pos_q + 1'b1;
					end
				end else if (is_status && !space_q) begin
					ab_space = (ch == hrp_pkg::CH_SPACE);
				end else begin
					ab_num = feed_num;
					ab_acc = feed_acc;
				end
			end
		end
	end

	// line end decision
	assign le_sel   = (item_s1.opcode == hrp_pkg::OP_DATA) && (ch != hrp_pkg::CH_LF);
	assign le_lc    = le_sel ? ab_lc : lc_q;
	assign le_cr    = le_sel ? (ch == hrp_pkg::CH_CR) : cr_q;
	assign le_alive = le_sel ? ab_alive : alive_q;
	assign le_space = le_sel ? ab_space : space_q;
	assign le_pos   = le_sel ? ab_pos : pos_q;
	assign le_num   = le_sel ? ab_num : num_q;
	assign le_acc   = le_sel ? ab_acc : acc_q;

	assign eff_zero = (le_lc == '0) || (le_lc == LC_W'(1) && le_cr);
	assign hdr_ok   = le_alive && le_pos == hrp_pkg::STATUS_PFX_LEN && le_space;
	assign code_new = le_num.neg ? 10'd0 : le_acc[9:0];
	assign code_ok  = !le_num.neg && le_acc >= LENGTH_BITS'(hrp_pkg::CODE_OK_LO) &&
		le_acc < LENGTH_BITS'(hrp_pkg::CODE_OK_HI);
	assign len_hit  = le_alive && le_pos == hrp_pkg::LENGTH_PFX_LEN;
	assign len_new  = le_num.sat ? '1 : (le_num.neg ? LENGTH_BITS'(0) - le_acc : le_acc);

	always_comb begin
		el_fin     = 1'b0;
		el_st      = hrp_pkg::ST_OK;
		el_clear   = 1'b0;
		el_code_we = 1'b0;
		el_len_we  = 1'b0;
		el_to_head = 1'b0;
		el_to_body = 1'b0;
		if (is_status) begin
			if (!hdr_ok) begin
				el_fin = 1'b1;
				el_st  = hrp_pkg::ST_HEADER;
			end else begin
				el_code_we = 1'b1;
				if (!code_ok) begin
					el_fin = 1'b1;
					el_st  = hrp_pkg::ST_STATUS;
				end else begin
					el_to_head = 1'b1;
					el_clear   = 1'b1;
				end
			end
		end else if (eff_zero) begin
			el_clear = 1'b1;
			if (!lseen_q) begin
				el_fin = 1'b1;
				el_st  = hrp_pkg::ST_NOLEN;
			end else if (len_q == '0) begin
				el_fin = 1'b1;
				el_st  = hrp_pkg::ST_OK;
			end else begin
				el_to_body = 1'b1;
			end
		end else begin
			el_len_we = len_hit;
			el_clear  = 1'b1;
		end
	end

	// next state and result
	assign rcv_inc = rcv_q + 1'b1;

	always_comb begin
		phase_d = phase_q;
		lc_d    = lc_q;
		pos_d   = pos_q;
		alive_d = alive_q;
		space_d = space_q;
		cr_d    = cr_q;
		tend_d  = tend_q;
		num_d   = num_q;
		acc_d   = acc_q;
		code_d  = code_q;
		len_d   = len_q;
		lseen_d = lseen_q;
		rcv_d   = rcv_q;
		produce = 1'b0;
		run_el  = 1'b0;
		eos     = 1'b0;
		res_d.body_valid = 1'b0;
		res_d.body_octet = 8'd0;
		res_d.done_res   = 1'b0;
		res_d.status     = hrp_pkg::ST_OK;
		if (item_s1.opcode == hrp_pkg::OP_RESTART) begin
			phase_d = PH_STATUS;
			lc_d    = '0;
			pos_d   = 4'd0;
			alive_d = 1'b1;
			space_d = 1'b0;
			cr_d    = 1'b0;
			tend_d  = 1'b0;
			num_d   = '{mode: hrp_pkg::NUM_SKIP, neg: 1'b0, sat: 1'b0};
			acc_d   = '0;
			code_d  = 10'd0;
			len_d   = '0;
			lseen_d = 1'b0;
			rcv_d   = '0;
		end else if (phase_q != PH_DONE) begin
			case (item_s1.opcode)
				hrp_pkg::OP_ERROR: begin
					phase_d = PH_DONE;
					produce = 1'b1;
					res_d.done_res = 1'b1;
					res_d.status   = hrp_pkg::ST_RECV;
				end
				hrp_pkg::OP_EOS: begin
					if (phase_q == PH_BODY) begin
						phase_d = PH_DONE;
						produce = 1'b1;
						res_d.done_res = 1'b1;
						res_d.status   = hrp_pkg::ST_TRUNC;
					end else if (lc_q == '0) begin
						phase_d = PH_DONE;
						produce = 1'b1;
						res_d.done_res = 1'b1;
						res_d.status   = hrp_pkg::ST_RECV;
					end else begin
						run_el = 1'b1;
						eos    = 1'b1;
					end
				end
				hrp_pkg::OP_DATA: begin
					if (phase_q == PH_BODY) begin
						rcv_d   = rcv_inc;
						produce = 1'b1;
						res_d.body_valid = 1'b1;
						res_d.body_octet = ch;
						if (rcv_inc >= len_q) begin
							phase_d = PH_DONE;
							res_d.done_res = 1'b1;
						end
					end else if (ch == hrp_pkg::CH_LF) begin
						run_el = 1'b1;
					end else begin
						lc_d    = ab_lc;
						cr_d    = (ch == hrp_pkg::CH_CR);
						pos_d   = ab_pos;
						alive_d = ab_alive;
						space_d = ab_space;
						tend_d  = ab_tend;
						num_d   = ab_num;
						acc_d   = ab_acc;
						run_el  = (ab_lc >= LC_LIMIT);
					end
				end
				default: begin
				end
			endcase
			if (run_el) begin
				if (el_code_we) begin
					code_d = code_new;
				end
				if (el_len_we) begin
					len_d   = len_new;
					lseen_d = 1'b1;
				end
				if (el_clear) begin
					lc_d    = '0;
					pos_d   = 4'd0;
					alive_d = 1'b1;
					space_d = 1'b0;
					cr_d    = 1'b0;
					tend_d  = 1'b0;
					num_d   = '{mode: hrp_pkg::NUM_SKIP, neg: 1'b0, sat: 1'b0};
					acc_d   = '0;
				end
				if (el_to_head) begin
					phase_d = PH_HEAD;
				end
				if (el_to_body) begin
					phase_d = PH_BODY;
				end
				if (el_fin) begin
					phase_d = PH_DONE;
					produce = 1'b1;
					res_d.done_res = 1'b1;
					res_d.status   = el_st;
				end else if (eos) begin
					phase_d = PH_DONE;
					produce = 1'b1;
					res_d.done_res = 1'b1;
					res_d.status   = el_to_body ? hrp_pkg::ST_TRUNC : hrp_pkg::ST_RECV;
				end
			end
		end
		res_d.response_code = code_d;
		res_d.body_length   = 32'd0;
		res_d.body_count    = 32'd0;
	end

	// 32-bit view of length and count
	if (LENGTH_BITS > 32) begin : g_sat
		assign len_out = (|len_d[LENGTH_BITS-1:32]) ? '1 : len_d[31:0];
		assign rcv_out = (|rcv_d[LENGTH_BITS-1:32]) ? '1 : rcv_d[31:0];
	end else begin : g_ext
		assign len_out = 32'(len_d);
		assign rcv_out = 32'(rcv_d);
	end

	always_comb begin
		res_full             = res_d;
		res_full.body_length = len_out;
		res_full.body_count  = rcv_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STATUS;
			lc_q        <= '0;
			pos_q       <= 4'd0;
			alive_q     <= 1'b1;
			space_q     <= 1'b0;
			cr_q        <= 1'b0;
			tend_q      <= 1'b0;
			num_q       <= '{mode: hrp_pkg::NUM_SKIP, neg: 1'b0, sat: 1'b0};
			acc_q       <= '0;
			code_q      <= 10'd0;
			len_q       <= '0;
			lseen_q     <= 1'b0;
			rcv_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q <= phase_d;
				lc_q    <= lc_d;
				pos_q   <= pos_d;
				alive_q <= alive_d;
				space_q <= space_d;
				cr_q    <= cr_d;
				tend_q  <= tend_d;
				num_q   <= num_d;
				acc_q   <= acc_d;
				code_q  <= code_d;
				len_q   <= len_d;
				lseen_q <= lseen_d;
				rcv_q   <= rcv_d;
			end
			if (adv && produce) begin
				res_valid_q <= 1'b1;
				res_q       <= res_full;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_body_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> lseen_q && len_q != '0)
		else $error("body phase without a declared nonzero length");

	a_count_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> rcv_q < len_q)
		else $error("body count reached length without finishing");

	a_line_cut: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DONE |-> lc_q < LC_LIMIT)
		else $error("line length passed the cut limit");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && produce && res_d.done_res |=> phase_q == PH_DONE)
		else $error("finished response not in done phase");

endmodule
